### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Shared assertion macros for the colormap core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must never be true
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("assertion failed");

// consequence must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### rtl/core/lsgc_pkg.sv
// ----------------------------------------------------------------------------
// lsgc_pkg
// Types and constants shared by the log scale colormap core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package lsgc_pkg;

	localparam int NUM_BANDS_DEF       = 5;
	localparam int VALUE_FRAC_BITS_DEF = 12;

	localparam int SAMPLE_W  = 32;
	localparam int SHADE_W   = 10;
	localparam int COLOR_W   = 24;
	localparam int PAIR_W    = 48;
	localparam int CH_W      = 8;
	localparam int CFG_W     = 48;
	localparam int CFG_IDX_W = 3;
	localparam int BAND_SLOTS = 5;
	localparam int BAND_W    = 3;

	localparam int LOG_STEPS = 28;
	localparam int Y_W       = 40;
	localparam int K_W       = 14;
	localparam int PROD_W    = 18;
	localparam int DIV_STEPS = 8;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [31:0] LOG10_2_Q32 = 32'h4D104D42;
	localparam logic [Y_W-1:0] LOG_OFFSET = Y_W'(64'h1_0000_0040);

	localparam logic [SHADE_W-1:0] SHADES_RST    = 10'd100;
	localparam logic [SAMPLE_W-1:0] MARKER_RST   = 32'd0;
	localparam logic [COLOR_W-1:0] OOS_COLOR_RST = 24'hFFFFFF;
	localparam logic [PAIR_W-1:0] BAND0_RST = 48'h000000000000;
	localparam logic [PAIR_W-1:0] BAND1_RST = 48'h04008547A9FF;
	localparam logic [PAIR_W-1:0] BAND2_RST = 48'h00631E47D171;
	localparam logic [PAIR_W-1:0] BAND3_RST = 48'h8F0000FF8080;
	localparam logic [PAIR_W-1:0] BAND4_RST = 48'h4B0066E18FFF;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SHADES    = 3'd0,
		REG_MARKER    = 3'd1,
		REG_OOS_COLOR = 3'd2,
		REG_BAND0     = 3'd3,
		REG_BAND1     = 3'd4,
		REG_BAND2     = 3'd5,
		REG_BAND3     = 3'd6,
		REG_BAND4     = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [SHADE_W-1:0]  shades;
		logic [SAMPLE_W-1:0] marker;
		logic [COLOR_W-1:0]  oos_color;
		logic [BAND_SLOTS-1:0][PAIR_W-1:0] bands;
	} cfg_t;

	typedef struct packed {
		logic           oos;
		logic [K_W-1:0] k;
	} shade_item_t;

	// shade count with values below two taken as two
	function automatic logic [SHADE_W-1:0] eff_shades(input logic [SHADE_W-1:0] s);
		eff_shades = (s < SHADE_W'(2)) ? SHADE_W'(2) : s;
	endfunction

endpackage

### rtl/core/log_scale_gradient_colormap_unit.sv
// ----------------------------------------------------------------------------
// log_scale_gradient_colormap_unit
// Maps a UQ fixed-point sample to an RGB888 color on a log-decade gradient.
// ----------------------------------------------------------------------------
// channel   signals                               direction
// input     in_valid in_ready sample_value        in
// output    out_valid out_ready red green blue beyond_scale   out
// config    cfg_write cfg_index cfg_data          in
//
// one item per clock sustained while out_ready stays high; the log pipeline
// (normalize, 28 squaring stages, three scaling stages) is followed by the
// queue, then band select, blend and divider, one quotient bit per stage
// a stall on the output holds the back part; the queue absorbs up to four
// items before the front part stops taking samples
// reset is asynchronous and loads the default palette and shade count
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module log_scale_gradient_colormap_unit import lsgc_pkg::*; #(
	parameter int NUM_BANDS       = NUM_BANDS_DEF,
	parameter int VALUE_FRAC_BITS = VALUE_FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [SAMPLE_W-1:0]  sample_value,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [CH_W-1:0]      red,
	output logic [CH_W-1:0]      green,
	output logic [CH_W-1:0]      blue,
	output logic                 beyond_scale
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.shades    <= SHADES_RST;
			cfg_q.marker    <= MARKER_RST;
			cfg_q.oos_color <= OOS_COLOR_RST;
			cfg_q.bands[0]  <= BAND0_RST;
			cfg_q.bands[1]  <= BAND1_RST;
			cfg_q.bands[2]  <= BAND2_RST;
			cfg_q.bands[3]  <= BAND3_RST;
			cfg_q.bands[4]  <= BAND4_RST;
		end else if (cfg_write) begin
			case (cfg_reg_t'(cfg_index))
				REG_SHADES:    cfg_q.shades    <= cfg_data[SHADE_W-1:0];
				REG_MARKER:    cfg_q.marker    <= cfg_data[SAMPLE_W-1:0];
				REG_OOS_COLOR: cfg_q.oos_color <= cfg_data[COLOR_W-1:0];
				REG_BAND0:     cfg_q.bands[0]  <= cfg_data;
				REG_BAND1:     cfg_q.bands[1]  <= cfg_data;
				REG_BAND2:     cfg_q.bands[2]  <= cfg_data;
				REG_BAND3:     cfg_q.bands[3]  <= cfg_data;
				REG_BAND4:     cfg_q.bands[4]  <= cfg_data;
				default: ;
			endcase
		end
	end

	logic        f_valid, f_ready, b_valid, b_ready;
	shade_item_t f_item, b_item;

	lsgc_front #(.VALUE_FRAC_BITS(VALUE_FRAC_BITS)) u_front (
		.clk, .arst_n, .cfg(cfg_q),
		.in_valid, .in_ready, .sample_value,
		.out_valid(f_valid), .out_ready(f_ready), .out_item(f_item)
	);

	lsgc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk, .arst_n,
		.in_valid(f_valid), .in_ready(f_ready), .in_item(f_item),
		.out_valid(b_valid), .out_ready(b_ready), .out_item(b_item)
	);

	lsgc_back #(.NUM_BANDS(NUM_BANDS)) u_back (
		.clk, .arst_n, .cfg(cfg_q),
		.in_valid(b_valid), .in_ready(b_ready), .in_item(b_item),
		.out_valid, .out_ready, .red, .green, .blue, .beyond_scale
	);

endmodule

### rtl/core/lsgc_front.sv
// ----------------------------------------------------------------------------
// lsgc_front
// Classifies samples and computes the shade index from a fixed-point log10.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lsgc_front import lsgc_pkg::*; #(
	parameter int VALUE_FRAC_BITS = VALUE_FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cfg_t                cfg,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [SAMPLE_W-1:0] sample_value,
	output logic                out_valid,
	input  logic                out_ready,
	output shade_item_t         out_item
);

	localparam int ST = LOG_STEPS;

	function automatic logic [4:0] lead_one(input logic [SAMPLE_W-1:0] x);
		logic [4:0] r;
		r = 5'd0;
		for (int i = 0; i < SAMPLE_W; i++) begin
			if (x[i]) r = 5'(i);
		end
		lead_one = r;
	endfunction

	logic en;
	logic [4:0] e_c;

	// squaring pipeline, index 0 is the normalized sample
	logic              v_sq_s   [0:ST];
	logic [31:0]       m_sq_s   [0:ST];
	logic [ST-1:0]     f_sq_s   [0:ST];
	logic [4:0]        e_sq_s   [0:ST];
	logic              oos_sq_s [0:ST];
	logic              zero_sq_s[0:ST];

	logic                  v_p_s, oos_p_s, zero_p_s;
	logic [59:0]           fc_p_s;
	logic signed [Y_W-1:0] nc_p_s;
	logic                  v_y_s, oos_y_s, zero_y_s;
	logic signed [Y_W-1:0] y_y_s;
	logic                  v_k_s;
	shade_item_t           item_k_s;

	assign en       = !v_k_s || out_ready;
	assign in_ready = en;
	assign e_c      = lead_one(sample_value);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sq_s[0] <= 1'b0;
		end else if (en) begin
			v_sq_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_sq_s[0]    <= sample_value << (5'd31 - e_c);
			f_sq_s[0]    <= '0;
			e_sq_s[0]    <= e_c;
			oos_sq_s[0]  <= (sample_value == cfg.marker);
			zero_sq_s[0] <= (sample_value == '0);
		end
	end

	for (genvar i = 0; i < ST; i++) begin : g_sq
		logic [63:0] prod;
		logic [32:0] sh;
		assign prod = 64'(m_sq_s[i]) * 64'(m_sq_s[i]);
		assign sh   = prod[63:31];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sq_s[i+1] <= 1'b0;
			end else if (en) begin
				v_sq_s[i+1] <= v_sq_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				m_sq_s[i+1]    <= sh[32] ? sh[32:1] : sh[31:0];
				f_sq_s[i+1]    <= {f_sq_s[i][ST-2:0], sh[32]};
				e_sq_s[i+1]    <= e_sq_s[i];
				oos_sq_s[i+1]  <= oos_sq_s[i];
				zero_sq_s[i+1] <= zero_sq_s[i];
			end
		end
	end

	// integer part of log2 relative to the binary point
	logic signed [6:0]     n_c;
	logic signed [Y_W-1:0] nc_c;
	logic signed [Y_W-1:0] y_c;
	logic [Y_W+SHADE_W-1:0] ky_c;
	logic [K_W-1:0]        k_c;

	assign n_c  = $signed({2'b00, e_sq_s[ST]}) - 7'(VALUE_FRAC_BITS);
	assign nc_c = $signed({{(Y_W-7){n_c[6]}}, n_c})
		* $signed({{(Y_W-32){1'b0}}, LOG10_2_Q32});
	assign y_c  = nc_p_s + $signed(Y_W'(fc_p_s[59:28])) + $signed(LOG_OFFSET);
	assign ky_c = (Y_W+SHADE_W)'(eff_shades(cfg.shades))
		* (Y_W+SHADE_W)'(y_y_s[Y_W-2:0]);
	assign k_c  = (zero_y_s || y_y_s[Y_W-1] || y_y_s == '0) ? '0 : ky_c[32 +: K_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_p_s <= 1'b0;
			v_y_s <= 1'b0;
			v_k_s <= 1'b0;
		end else if (en) begin
			v_p_s <= v_sq_s[ST];
			v_y_s <= v_p_s;
			v_k_s <= v_y_s;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fc_p_s      <= 60'(f_sq_s[ST]) * 60'(LOG10_2_Q32);
			nc_p_s      <= nc_c;
			oos_p_s     <= oos_sq_s[ST];
			zero_p_s    <= zero_sq_s[ST];
			y_y_s       <= y_c;
			oos_y_s     <= oos_p_s;
			zero_y_s    <= zero_p_s;
			item_k_s.k   <= k_c;
			item_k_s.oos <= oos_y_s;
		end
	end

	assign out_valid = v_k_s;
	assign out_item  = item_k_s;

	`ASSERT_NEXT(a_front_hold, clk, arst_n, v_k_s && !out_ready, v_k_s)

endmodule

### rtl/core/lsgc_queue.sv
// ----------------------------------------------------------------------------
// lsgc_queue
// Small first-in first-out buffer between the index and color stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lsgc_queue import lsgc_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  shade_item_t in_item,
	output logic        out_valid,
	input  logic        out_ready,
	output shade_item_t out_item
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	shade_item_t   mem_q [0:DEPTH-1];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;
	logic          push, pop;

	assign in_ready  = (cnt_q != CW'(DEPTH));
	assign out_valid = (cnt_q != '0);
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_item  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)  rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= in_item;
	end

	`ASSERT_NEVER(a_q_count, clk, arst_n, cnt_q > CW'(DEPTH))
	`ASSERT_NEXT(a_q_fill, clk, arst_n, push && !pop, cnt_q == $past(cnt_q) + 1'b1)

endmodule

### rtl/core/lsgc_back.sv
// ----------------------------------------------------------------------------
// lsgc_back
// Picks the band and blends start and end colors with a pipelined divider.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module lsgc_back import lsgc_pkg::*; #(
	parameter int NUM_BANDS = NUM_BANDS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  cfg_t            cfg,
	input  logic            in_valid,
	output logic            in_ready,
	input  shade_item_t     in_item,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [CH_W-1:0] red,
	output logic [CH_W-1:0] green,
	output logic [CH_W-1:0] blue,
	output logic            beyond_scale
);

	localparam int DS = DIV_STEPS;

	logic en;
	logic [SHADE_W-1:0] s_c, dv_c;
	logic [BAND_W-1:0]  band_c;
	logic [K_W-1:0]     base_c;
	logic               beyond_c;
	logic [PAIR_W-1:0]  pair_c;

	assign s_c  = eff_shades(cfg.shades);
	assign dv_c = s_c - 1'b1;

	always_comb begin
		band_c = '0;
		for (int b = 1; b < NUM_BANDS; b++) begin
			if (in_item.k >= K_W'(b) * K_W'(s_c)) band_c = BAND_W'(b);
		end
	end

	assign base_c   = K_W'(band_c) * K_W'(s_c);
	assign beyond_c = in_item.oos || (in_item.k >= K_W'(NUM_BANDS) * K_W'(s_c));
	assign pair_c   = cfg.bands[band_c];

	// stage 1: band and step
	logic                v_s1, beyond_s1;
	logic [COLOR_W-1:0]  st_s1, en_s1;
	logic [SHADE_W-1:0]  j_s1;

	// stage 2: magnitude of color delta times step
	logic                v_s2, beyond_s2;
	logic [2:0][CH_W-1:0]   st_s2;
	logic [2:0]             neg_s2;
	logic [2:0][PROD_W-1:0] pr_s2;

	// divider stages, index 0 is the stage 2 result
	logic                   v_dv_s   [0:DS];
	logic                   bey_dv_s [0:DS];
	logic [2:0]             neg_dv_s [0:DS];
	logic [2:0][CH_W-1:0]   st_dv_s  [0:DS];
	logic [2:0][PROD_W-1:0] rem_dv_s [0:DS];
	logic [2:0][CH_W-1:0]   q_dv_s   [0:DS];

	logic                  ov_q;
	logic [2:0][CH_W-1:0]  col_q;
	logic                  bey_q;

	assign en       = !ov_q || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			ov_q <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			ov_q <= v_dv_s[DS];
		end
	end

	logic [2:0][CH_W-1:0] st_ch, en_ch;
	logic [2:0][CH_W:0]   d_ch;
	logic [2:0][CH_W-1:0] mag_ch;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			st_ch[c]  = st_s1[c*CH_W +: CH_W];
			en_ch[c]  = en_s1[c*CH_W +: CH_W];
			d_ch[c]   = {1'b0, en_ch[c]} - {1'b0, st_ch[c]};
			mag_ch[c] = d_ch[c][CH_W] ? CH_W'(-d_ch[c]) : d_ch[c][CH_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s1     <= pair_c[PAIR_W-1:COLOR_W];
			en_s1     <= pair_c[COLOR_W-1:0];
			j_s1      <= SHADE_W'(in_item.k - base_c);
			beyond_s1 <= beyond_c;
			beyond_s2 <= beyond_s1;
			st_s2     <= st_ch;
			for (int c = 0; c < 3; c++) begin
				neg_s2[c] <= d_ch[c][CH_W];
				pr_s2[c]  <= PROD_W'(mag_ch[c]) * PROD_W'(j_s1);
			end
		end
	end

	always_comb begin
		v_dv_s[0]   = v_s2;
		bey_dv_s[0] = beyond_s2;
		neg_dv_s[0] = neg_s2;
		st_dv_s[0]  = st_s2;
		rem_dv_s[0] = pr_s2;
		q_dv_s[0]   = '0;
	end

	// restoring division, one quotient bit per stage from the top
	for (genvar i = 0; i < DS; i++) begin : g_div
		logic [PROD_W-1:0] dsh;
		assign dsh = PROD_W'(dv_c) << (DS - 1 - i);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_dv_s[i+1] <= 1'b0;
			end else if (en) begin
				v_dv_s[i+1] <= v_dv_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				bey_dv_s[i+1] <= bey_dv_s[i];
				neg_dv_s[i+1] <= neg_dv_s[i];
				st_dv_s[i+1]  <= st_dv_s[i];
				for (int c = 0; c < 3; c++) begin
					if (rem_dv_s[i][c] >= dsh) begin
						rem_dv_s[i+1][c] <= rem_dv_s[i][c] - dsh;
						q_dv_s[i+1][c]   <= q_dv_s[i][c] | CH_W'(1 << (DS - 1 - i));
					end else begin
						rem_dv_s[i+1][c] <= rem_dv_s[i][c];
						q_dv_s[i+1][c]   <= q_dv_s[i][c];
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			bey_q <= bey_dv_s[DS];
			for (int c = 0; c < 3; c++) begin
				if (bey_dv_s[DS]) begin
					col_q[c] <= cfg.oos_color[c*CH_W +: CH_W];
				end else if (neg_dv_s[DS][c]) begin
					col_q[c] <= st_dv_s[DS][c] - q_dv_s[DS][c];
				end else begin
					col_q[c] <= st_dv_s[DS][c] + q_dv_s[DS][c];
				end
			end
		end
	end

	assign out_valid    = ov_q;
	assign red          = col_q[2];
	assign green        = col_q[1];
	assign blue         = col_q[0];
	assign beyond_scale = bey_q;

	`ASSERT_NEXT(a_back_hold, clk, arst_n, ov_q && !out_ready, ov_q)

endmodule

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives random and edge-case samples into the log scale colormap unit under
// bursty input and a stalling output, predicts each color from a fixed-point
// log10 model and checks every result in order against that prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_top;
	import lsgc_pkg::*;

	localparam int  LIMIT_CYCLES = 400000;
	localparam int  DRAIN_CYCLES = 80;
	localparam int  RAND_ITEMS   = 1000;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
		logic            oos;
	} color_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_write;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	logic [SAMPLE_W-1:0]  sample_value;
	logic                 out_valid;
	logic                 out_ready;
	logic [CH_W-1:0]      red;
	logic [CH_W-1:0]      green;
	logic [CH_W-1:0]      blue;
	logic                 beyond_scale;

	// predictor copy of the registers
	logic [SHADE_W-1:0]  shades_q;
	logic [SAMPLE_W-1:0] marker_q;
	logic [COLOR_W-1:0]  oos_color_q;
	logic [PAIR_W-1:0]   band_q [BAND_SLOTS];

	logic [SAMPLE_W-1:0] sample_queue[$];
	color_t              color_queue[$];
	int                  errors;
	int                  checked;
	int                  oos_seen;
	longint              cycle_cnt;
	int                  hold_off;
	int                  long_holds;
	int                  burst_left;
	int                  gap_left;
	logic                in_accepted;

	log_scale_gradient_colormap_unit u_top (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [CH_W-1:0] blend_channel(input int st, input int en,
			input int step, input int s);
		int q;
		q = ((en - st) * step) / (s - 1);
		return CH_W'(st + q);
	endfunction

	// fixed-point log10(v) + 1 in Q.32, biased so exact decades land right
	function automatic longint log10_plus_one(input logic [SAMPLE_W-1:0] v);
		int     e;
		logic [63:0] m;
		logic [63:0] f;
		longint n;
		e = 31;
		while (!v[e]) e--;
		m = (64'(v) << (31 - e)) & 64'hFFFF_FFFF;
		f = 0;
		for (int i = 0; i < LOG_STEPS; i++) begin
			m = (m * m) >> 31;
			f = f << 1;
			if (m >= 64'h1_0000_0000) begin
				m = m >> 1;
				f[0] = 1'b1;
			end
		end
		n = longint'(e) - 12;
		return n * longint'(LOG10_2_Q32) + longint'((f * 64'(LOG10_2_Q32)) >> LOG_STEPS)
			+ 64'h1_0000_0040;
	endfunction

	function automatic color_t map_color(input logic [SAMPLE_W-1:0] v);
		color_t      c;
		int          s;
		longint      y;
		logic [63:0] k;
		int          b;
		int          j;
		logic [PAIR_W-1:0] pair;
		s = (shades_q < 2) ? 2 : int'(shades_q);
		k = 0;
		c = {oos_color_q, 1'b1};
		if (v != marker_q) begin
			if (v != 0) begin
				y = log10_plus_one(v);
				if (y > 0) k = (64'(s) * 64'(y)) >> 32;
			end
			if (k < 64'(NUM_BANDS_DEF * s)) begin
				b = int'(k / s);
				j = int'(k % s);
				pair = band_q[b];
				c.red   = blend_channel(int'(pair[47:40]), int'(pair[23:16]), j, s);
				c.green = blend_channel(int'(pair[39:32]), int'(pair[15:8]), j, s);
				c.blue  = blend_channel(int'(pair[31:24]), int'(pair[7:0]), j, s);
				c.oos   = 1'b0;
			end
		end
		return c;
	endfunction

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_write <= 1'b0;
		case (idx)
			REG_SHADES:    shades_q    = val[SHADE_W-1:0];
			REG_MARKER:    marker_q    = val[SAMPLE_W-1:0];
			REG_OOS_COLOR: oos_color_q = val[COLOR_W-1:0];
			default:       band_q[idx - REG_BAND0] = val[PAIR_W-1:0];
		endcase
	endtask

	task automatic wait_idle();
		wait (sample_queue.size() == 0 && color_queue.size() == 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// random values, the marker and values near decade boundaries, which reach every band
	function automatic logic [SAMPLE_W-1:0] rand_sample();
		int sel;
		logic [SAMPLE_W-1:0] base;
		sel = $urandom_range(0, 9);
		if (sel < 3) return $urandom();
		if (sel == 3) return marker_q;
		base = SAMPLE_W'(410) * (10 ** $urandom_range(0, 5));
		if (sel < 6) return base + $urandom_range(0, 3) - 2;
		return $urandom() >> $urandom_range(0, 31);
	endfunction

	task automatic run_phase(input int n);
		for (int i = 0; i < n; i++) sample_queue = {sample_queue, rand_sample()};
		wait_idle();
	endtask

	// driver: bursts of random length with random gaps
	// the head of the queue is the item on the bus until it is accepted
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid   <= 1'b0;
			burst_left <= 0;
			gap_left   <= 0;
		end else if (!in_valid || in_accepted) begin
			if (in_valid) void'(sample_queue.pop_front());
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if (sample_queue.size() > 0) begin
				in_valid     <= 1'b1;
				sample_value <= sample_queue[0];
				if (burst_left == 0) begin
					burst_left <= $urandom_range(1, 40);
					gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver stall pattern, with a long hold-off now and then
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready  <= 1'b0;
			hold_off   <= 0;
			long_holds <= 0;
		end else if (hold_off > 0) begin
			hold_off  <= hold_off - 1;
			out_ready <= 1'b0;
		end else if (long_holds == 0 && in_valid && checked > 20) begin
			// first long hold-off while the sender is busy fills the whole unit
			hold_off   <= 120;
			out_ready  <= 1'b0;
			long_holds <= long_holds + 1;
		end else if ($urandom_range(0, 299) == 0) begin
			hold_off  <= 120;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ((cycle_cnt / 64) % 3 == 0) ? 1'b1 : ($urandom_range(0, 3) != 0);
		end
	end

	// predict at acceptance, check at each output handshake
	always @(posedge clk) begin
		color_t want;
		color_t got;
		cycle_cnt <= cycle_cnt + 1;
		in_accepted <= arst_n && in_valid && in_ready;
		if (arst_n && in_valid && in_ready)
			color_queue = {color_queue, map_color(sample_value)};
		if (arst_n && out_valid && out_ready) begin
			got = {red, green, blue, beyond_scale};
			if (color_queue.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
			end else begin
				want = color_queue.pop_front();
				checked++;
				if (got.oos) oos_seen++;
				if (got !== want) begin
					$display("%0t: color mismatch expected r%h g%h b%h oos%b actual r%h g%h b%h oos%b",
						$time, want.red, want.green, want.blue, want.oos,
						got.red, got.green, got.blue, got.oos);
					errors++;
				end
			end
		end
		if (cycle_cnt > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles", cycle_cnt);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		logic [SAMPLE_W-1:0] edge_vals [14];
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = REG_SHADES;
		cfg_data = '0;
		sample_value = '0;
		errors = 0;
		checked = 0;
		oos_seen = 0;
		cycle_cnt = 0;
		shades_q = SHADES_RST;
		marker_q = MARKER_RST;
		oos_color_q = OOS_COLOR_RST;
		band_q[0] = BAND0_RST;
		band_q[1] = BAND1_RST;
		band_q[2] = BAND2_RST;
		band_q[3] = BAND3_RST;
		band_q[4] = BAND4_RST;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// zero, marker, sub-0.1, decade edges, max
		edge_vals = '{32'd0, 32'd1, 32'd409, 32'd410, 32'd4096, 32'd4095, 32'd40960,
			32'd409600, 32'd4096000, 32'd40960000, 32'd409599999, 32'hFFFFFFFF,
			32'h80000000, 32'hAAAA5555};
		foreach (edge_vals[i]) sample_queue = {sample_queue, edge_vals[i]};
		wait_idle();

		write_reg(REG_SHADES, 48'd2);
		write_reg(REG_MARKER, 48'hFFFFFFFF);
		write_reg(REG_OOS_COLOR, 48'h123456);
		write_reg(REG_BAND0, 48'hFFFFFF000000);
		write_reg(REG_BAND1, 48'h000000FFFFFF);
		write_reg(REG_BAND2, 48'hFF00FF00FF00);
		write_reg(REG_BAND3, 48'h00FF0000FF00);
		write_reg(REG_BAND4, 48'h8080807F7F7F);
		run_phase(RAND_ITEMS / 4);

		write_reg(REG_SHADES, 48'd1023);
		write_reg(REG_MARKER, 48'd4096);
		write_reg(REG_OOS_COLOR, 48'h000000);
		run_phase(RAND_ITEMS / 4);

		write_reg(REG_SHADES, 48'd0);
		write_reg(REG_MARKER, {16'hFFFF, $urandom()});
		run_phase(RAND_ITEMS / 8);

		for (int i = 0; i < 3; i++) begin
			write_reg(REG_SHADES, CFG_W'($urandom_range(2, 1023)));
			for (int b = 0; b < BAND_SLOTS; b++)
				write_reg(cfg_reg_t'(REG_BAND0 + b), CFG_W'({$urandom(), $urandom()}));
			write_reg(REG_OOS_COLOR, CFG_W'($urandom()));
			run_phase(RAND_ITEMS * 3 / 24);
		end

		$display("checked %0d colors over several palettes, %0d out of scale",
			checked, oos_seen);
		if (errors == 0 && color_queue.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

### log_scale_gradient_colormap_unit.f
+incdir+rtl/core
rtl/core/lsgc_pkg.sv
rtl/core/lsgc_front.sv
rtl/core/lsgc_queue.sv
rtl/core/lsgc_back.sv
rtl/core/log_scale_gradient_colormap_unit.sv
verif/tb_top.sv
